@@ design/scpp_pkg.sv @@
`timescale 1ns / 1ps

package scpp_pkg;

   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam int PREFIX_LEN        = 19;
   localparam int PREFIX_INDEX_BITS = $clog2(PREFIX_LEN + 1);

   localparam logic [7:0] CHAR_COMMA   = 8'h2c;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_FIRST  = 3'd1,
      PH_SECOND = 3'd2,
      PH_TAIL   = 3'd3,
      PH_WRITE  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SEEK       = 2'd0,
      KIND_WRITE_NL   = 2'd1,
      KIND_WRITE_NONE = 2'd2
   } kind_type;

   // command prefix, one byte per position
   function automatic logic [7:0] prefix_byte(input logic [PREFIX_INDEX_BITS-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         5'd0:    b = 8'h41;
         5'd1:    b = 8'h45;
         5'd2:    b = 8'h53;
         5'd3:    b = 8'h44;
         5'd4:    b = 8'h43;
         5'd5:    b = 8'h48;
         5'd6:    b = 8'h41;
         5'd7:    b = 8'h52;
         5'd8:    b = 8'h5f;
         5'd9:    b = 8'h49;
         5'd10:   b = 8'h4f;
         5'd11:   b = 8'h43;
         5'd12:   b = 8'h53;
         5'd13:   b = 8'h45;
         5'd14:   b = 8'h45;
         5'd15:   b = 8'h4b;
         5'd16:   b = 8'h54;
         5'd17:   b = 8'h4f;
         5'd18:   b = 8'h3a;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ design/scpp_if.sv @@
`timescale 1ns / 1ps

interface scpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface scpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  packet_class;
   logic [31:0] seek_command;
   logic [31:0] seek_offset;
   logic [15:0] newline_position;
   logic [15:0] packet_size;

   modport source (output valid, output packet_class, output seek_command,
                   output seek_offset, output newline_position,
                   output packet_size, input ready);
   modport sink   (input valid, input packet_class, input seek_command,
                   input seek_offset, input newline_position,
                   input packet_size, output ready);
endinterface

@@ design/seek_command_packet_parser.sv @@
// A result is loaded into the result register when the word that ends its packet leaves the input register.
// Throughput: one word per cycle; the input register and the result register
// both advance in the same cycle, so a waiting result does not stall the other words.
// A final word stalls only while the result register holds an untaken result.
// Reset (synchronous, active high) clears the valid flags and all parse state.
`timescale 1ns / 1ps

module seek_command_packet_parser (
   input  logic              clock,
   input  logic              reset,
   scpp_req_if.sink          req_port,
   scpp_rsp_if.source        rsp_port
);

   localparam int CB = scpp_pkg::COUNT_BITS;
   localparam int IB = scpp_pkg::PREFIX_INDEX_BITS;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       req_accept;
   logic       s1_fire;

   // parse state
   scpp_pkg::phase_type phase_ff, phase_step, phase_in;
   logic [IB-1:0] prefix_index_ff, prefix_index_step;
   logic [31:0]   first_number_ff, first_number_step;
   logic [31:0]   second_number_ff, second_number_step;
   logic          digit_seen_ff, digit_seen_step;
   logic [CB-1:0] byte_count_ff, byte_count_step;
   logic [CB-1:0] newline_index_ff, newline_index_step;
   logic          newline_found_ff, newline_found_step;

   logic          is_digit;
   logic [3:0]    digit;
   logic          prefix_hit;
   logic          seek;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   scpp_pkg::kind_type   kind_ff, kind_in;
   logic [31:0]          command_ff, command_in;
   logic [31:0]          offset_ff, offset_in;
   logic [15:0]          nl_pos_ff, nl_pos_in;
   logic [15:0]          size_ff, size_in;

   assign s1_fire = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !s1_valid_ff || s1_fire;
   assign req_accept = req_port.valid && req_port.ready;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign is_digit   = (s1_byte_ff >= scpp_pkg::CHAR_ZERO) && (s1_byte_ff <= scpp_pkg::CHAR_NINE);
   assign digit      = 4'(s1_byte_ff - scpp_pkg::CHAR_ZERO);
   assign prefix_hit = (prefix_index_ff < IB'(scpp_pkg::PREFIX_LEN))
                    && (s1_byte_ff == scpp_pkg::prefix_byte(prefix_index_ff));

   // next phase
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         scpp_pkg::PH_PREFIX: begin
            if (!prefix_hit) begin
               phase_step = scpp_pkg::PH_WRITE;
            end else if (prefix_index_ff == IB'(scpp_pkg::PREFIX_LEN - 1)) begin
               phase_step = scpp_pkg::PH_FIRST;
            end
         end
         scpp_pkg::PH_FIRST: begin
            if (is_digit) begin
               phase_step = scpp_pkg::PH_FIRST;
            end else if (s1_byte_ff == scpp_pkg::CHAR_COMMA && digit_seen_ff) begin
               phase_step = scpp_pkg::PH_SECOND;
            end else begin
               phase_step = scpp_pkg::PH_WRITE;
            end
         end
         scpp_pkg::PH_SECOND: begin
            if (is_digit) begin
               phase_step = scpp_pkg::PH_SECOND;
            end else if (digit_seen_ff) begin
               phase_step = scpp_pkg::PH_TAIL;
            end else begin
               phase_step = scpp_pkg::PH_WRITE;
            end
         end
         default: phase_step = phase_ff;
      endcase
      phase_in = s1_last_ff ? scpp_pkg::PH_PREFIX : phase_step;
   end

   // datapath and result
   always_comb begin
      newline_found_step = newline_found_ff;
      newline_index_step = newline_index_ff;
      if (s1_byte_ff == scpp_pkg::CHAR_NEWLINE && !newline_found_ff) begin
         newline_found_step = 1'b1;
         newline_index_step = byte_count_ff;
      end
      byte_count_step = (byte_count_ff == scpp_pkg::COUNT_MAX) ? byte_count_ff
                                                               : byte_count_ff + 1'b1;

      prefix_index_step  = prefix_index_ff;
      first_number_step  = first_number_ff;
      second_number_step = second_number_ff;
      digit_seen_step    = digit_seen_ff;
      case (phase_ff)
         scpp_pkg::PH_PREFIX: begin
            if (prefix_hit) begin
               prefix_index_step = prefix_index_ff + 1'b1;
               digit_seen_step   = 1'b0;
            end
         end
         scpp_pkg::PH_FIRST: begin
            if (is_digit) begin
               first_number_step = {first_number_ff[28:0], 3'b000}
                                 + {first_number_ff[30:0], 1'b0} + {28'd0, digit};
               digit_seen_step   = 1'b1;
            end else if (s1_byte_ff == scpp_pkg::CHAR_COMMA && digit_seen_ff) begin
               digit_seen_step = 1'b0;
            end
         end
         scpp_pkg::PH_SECOND: begin
            if (is_digit) begin
               second_number_step = {second_number_ff[28:0], 3'b000}
                                  + {second_number_ff[30:0], 1'b0} + {28'd0, digit};
               digit_seen_step    = 1'b1;
            end
         end
         default: begin
         end
      endcase

      seek = (phase_step == scpp_pkg::PH_TAIL)
          || (phase_step == scpp_pkg::PH_SECOND && digit_seen_step);
      if (seek) begin
         kind_in    = scpp_pkg::KIND_SEEK;
         command_in = first_number_step;
         offset_in  = second_number_step;
         nl_pos_in  = 16'd0;
         size_in    = 16'd0;
      end else begin
         kind_in    = newline_found_step ? scpp_pkg::KIND_WRITE_NL
                                         : scpp_pkg::KIND_WRITE_NONE;
         command_in = 32'd0;
         offset_in  = 32'd0;
         nl_pos_in  = newline_found_step ? 16'(newline_index_step) : 16'(byte_count_step);
         size_in    = 16'(byte_count_step);
      end

      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_byte_ff <= req_port.data_byte;
         s1_last_ff <= req_port.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= scpp_pkg::PH_PREFIX;
         prefix_index_ff  <= '0;
         first_number_ff  <= '0;
         second_number_ff <= '0;
         digit_seen_ff    <= 1'b0;
         byte_count_ff    <= '0;
         newline_index_ff <= '0;
         newline_found_ff <= 1'b0;
      end else if (s1_fire) begin
         phase_ff <= phase_in;
         if (s1_last_ff) begin
            prefix_index_ff  <= '0;
            first_number_ff  <= '0;
            second_number_ff <= '0;
            digit_seen_ff    <= 1'b0;
            byte_count_ff    <= '0;
            newline_index_ff <= '0;
            newline_found_ff <= 1'b0;
         end else begin
            prefix_index_ff  <= prefix_index_step;
            first_number_ff  <= first_number_step;
            second_number_ff <= second_number_step;
            digit_seen_ff    <= digit_seen_step;
            byte_count_ff    <= byte_count_step;
            newline_index_ff <= newline_index_step;
            newline_found_ff <= newline_found_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire && s1_last_ff) begin
         kind_ff    <= kind_in;
         command_ff <= command_in;
         offset_ff  <= offset_in;
         nl_pos_ff  <= nl_pos_in;
         size_ff    <= size_in;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.packet_class     = kind_ff;
   assign rsp_port.seek_command     = command_ff;
   assign rsp_port.seek_offset      = offset_ff;
   assign rsp_port.newline_position = nl_pos_ff;
   assign rsp_port.packet_size      = size_ff;

endmodule

@@ verif/packet_verdict_monitor.sv @@
`timescale 1ns / 1ps

module packet_verdict_monitor (
   input  logic clock,
   input  logic reset,
   scpp_req_if  req_port,
   scpp_rsp_if  rsp_port,
   output int   fail_count,
   output int   results_due
);

   localparam logic [8*scpp_pkg::PREFIX_LEN-1:0] CMD_TAG =
      152'h41_45_53_44_43_48_41_52_5f_49_4f_43_53_45_45_4b_54_4f_3a;

   typedef struct packed {
      scpp_pkg::kind_type kind;
      logic [31:0]        command;
      logic [31:0]        offset;
      logic [15:0]        nl_pos;
      logic [15:0]        size;
   } parse_result_type;

   scpp_pkg::phase_type              phase;
   int unsigned                      tag_pos;
   logic [31:0]                      first_num;
   logic [31:0]                      second_num;
   logic                             have_digit;
   logic [scpp_pkg::COUNT_BITS-1:0]  seen_count;
   logic [scpp_pkg::COUNT_BITS-1:0]  nl_at;
   logic                             nl_seen;
   parse_result_type                 expected_results[$];
   int                               mismatches = 0;

   task automatic clear_parse();
      phase      = scpp_pkg::PH_PREFIX;
      tag_pos    = 0;
      first_num  = '0;
      second_num = '0;
      have_digit = 1'b0;
      seen_count = '0;
      nl_at      = '0;
      nl_seen    = 1'b0;
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      parse_result_type r;
      logic             digit;
      digit = (b >= scpp_pkg::CHAR_ZERO) && (b <= scpp_pkg::CHAR_NINE);
      if (b == scpp_pkg::CHAR_NEWLINE && !nl_seen) begin
         nl_seen = 1'b1;
         nl_at   = seen_count;
      end
      if (seen_count != scpp_pkg::COUNT_MAX)
         seen_count = seen_count + 1'b1;
      case (phase)
         scpp_pkg::PH_PREFIX: begin
            if (b == CMD_TAG[8*(scpp_pkg::PREFIX_LEN-1-tag_pos) +: 8]) begin
               tag_pos++;
               if (tag_pos == scpp_pkg::PREFIX_LEN) begin
                  phase      = scpp_pkg::PH_FIRST;
                  have_digit = 1'b0;
               end
            end else begin
               phase = scpp_pkg::PH_WRITE;
            end
         end
         scpp_pkg::PH_FIRST: begin
            if (digit) begin
               first_num  = first_num * 32'd10 + {24'd0, b - scpp_pkg::CHAR_ZERO};
               have_digit = 1'b1;
            end else if (b == scpp_pkg::CHAR_COMMA && have_digit) begin
               phase      = scpp_pkg::PH_SECOND;
               have_digit = 1'b0;
            end else begin
               phase = scpp_pkg::PH_WRITE;
            end
         end
         scpp_pkg::PH_SECOND: begin
            if (digit) begin
               second_num = second_num * 32'd10 + {24'd0, b - scpp_pkg::CHAR_ZERO};
               have_digit = 1'b1;
            end else if (have_digit) begin
               phase = scpp_pkg::PH_TAIL;
            end else begin
               phase = scpp_pkg::PH_WRITE;
            end
         end
         default: ;
      endcase
      if (last) begin
         if (phase == scpp_pkg::PH_TAIL || (phase == scpp_pkg::PH_SECOND && have_digit)) begin
            r.kind    = scpp_pkg::KIND_SEEK;
            r.command = first_num;
            r.offset  = second_num;
            r.nl_pos  = '0;
            r.size    = '0;
         end else begin
            r.kind    = nl_seen ? scpp_pkg::KIND_WRITE_NL : scpp_pkg::KIND_WRITE_NONE;
            r.command = '0;
            r.offset  = '0;
            r.nl_pos  = 16'(nl_seen ? nl_at : seen_count);
            r.size    = 16'(seen_count);
         end
         expected_results.push_back(r);
         clear_parse();
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic match_result();
      parse_result_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: result with none pending: expected none actual class %0d",
                  $time, rsp_port.packet_class);
         mismatches++;
      end else begin
         want = expected_results.pop_front();
         compare_field("packet_class", 32'(want.kind), 32'(rsp_port.packet_class));
         compare_field("seek_command", want.command, rsp_port.seek_command);
         compare_field("seek_offset", want.offset, rsp_port.seek_offset);
         compare_field("newline_position", 32'(want.nl_pos),
                       32'(rsp_port.newline_position));
         compare_field("packet_size", 32'(want.size), 32'(rsp_port.packet_size));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_results.delete();
      end else begin
         if (req_port.valid && req_port.ready)
            take_byte(req_port.data_byte, req_port.last_byte);
         if (rsp_port.valid && rsp_port.ready)
            match_result();
      end
      fail_count  <= mismatches;
      results_due <= expected_results.size();
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         fail_count;
   int         results_due;
   bit         calm;
   bit         hold_request;
   int         hold_left;
   int         words_sent;
   logic [7:0] packet_bytes[$];

   scpp_req_if req_chan();
   scpp_rsp_if rsp_chan();

   seek_command_packet_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan),
      .rsp_port (rsp_chan)
   );

   packet_verdict_monitor verdict_mon (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_chan),
      .rsp_port    (rsp_chan),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #8_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 200;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(99) >= 30);
         end
      end
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         packet_bytes.push_back(s[i]);
   endtask

   task automatic add_tag(input int upto);
      logic [scpp_pkg::PREFIX_INDEX_BITS-1:0] idx;
      for (int i = 0; i < upto; i++) begin
         idx = i[scpp_pkg::PREFIX_INDEX_BITS-1:0];
         packet_bytes.push_back(scpp_pkg::prefix_byte(idx));
      end
   endtask

   task automatic add_digits(input int n);
      for (int i = 0; i < n; i++)
         packet_bytes.push_back(scpp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic add_noise(input int n);
      for (int i = 0; i < n; i++)
         packet_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet_bytes.size(); i++) begin
         while (!calm && $urandom_range(99) < 30) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         req_chan.valid     <= 1'b1;
         req_chan.data_byte <= packet_bytes[i];
         req_chan.last_byte <= (i == packet_bytes.size() - 1);
         @(posedge clock);
         while (!req_chan.ready)
            @(posedge clock);
         words_sent++;
      end
   endtask

   task automatic send_seek_text(input int tag_len, input string body);
      packet_bytes.delete();
      add_tag(tag_len);
      add_text(body);
      send_packet();
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0)
         @(posedge clock);
   endtask

   task automatic make_random_packet(input bit tiny);
      int pick;
      int flip;
      pick = tiny ? 99 : $urandom_range(99);
      packet_bytes.delete();
      if (pick < 45) begin
         add_tag(scpp_pkg::PREFIX_LEN);
         add_digits($urandom_range(1, 12));
         add_text(",");
         add_digits($urandom_range(1, 12));
         if ($urandom_range(1))
            add_noise($urandom_range(1, 6));
      end else if (pick < 65) begin
         case ($urandom_range(3))
            0: add_tag($urandom_range(1, scpp_pkg::PREFIX_LEN));
            1: begin
               add_tag(scpp_pkg::PREFIX_LEN);
               flip = $urandom_range(scpp_pkg::PREFIX_LEN - 1);
               packet_bytes[flip] = packet_bytes[flip] ^ (8'd1 << $urandom_range(7));
               add_digits($urandom_range(1, 3));
               add_text(",");
               add_digits($urandom_range(1, 3));
            end
            2: begin
               add_tag(scpp_pkg::PREFIX_LEN);
               add_digits($urandom_range(0, 3));
               if ($urandom_range(1))
                  add_text(",");
               if ($urandom_range(1))
                  add_noise(1);
            end
            default: begin
               add_tag(scpp_pkg::PREFIX_LEN);
               add_digits($urandom_range(1, 4));
               add_text(",");
               add_noise($urandom_range(1, 3));
            end
         endcase
      end else begin
         for (int i = 0; i < (tiny ? $urandom_range(1, 3) : $urandom_range(1, 40)); i++)
            packet_bytes.push_back(($urandom_range(4) == 0) ? scpp_pkg::CHAR_NEWLINE
                                                             : 8'($urandom_range(255)));
      end
   endtask

   initial begin
      int  start;
      int  progress;
      bit  burst_done;
      bit  paused;
      logic [7:0] b;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.last_byte = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      packet_bytes.delete();
      packet_bytes.push_back(8'h00);
      send_packet();
      packet_bytes.delete();
      packet_bytes.push_back(8'hff);
      send_packet();
      send_seek_text(0, "\n");
      send_seek_text(0, "ab\ncd\n");
      send_seek_text(scpp_pkg::PREFIX_LEN, "4294967295,4294967295");
      send_seek_text(scpp_pkg::PREFIX_LEN, "4294967296,99999999999");
      send_seek_text(scpp_pkg::PREFIX_LEN, "0,0");
      send_seek_text(scpp_pkg::PREFIX_LEN, "12,34x\n,56");
      send_seek_text(10, "");
      send_seek_text(scpp_pkg::PREFIX_LEN, "");
      send_seek_text(scpp_pkg::PREFIX_LEN, "12");
      send_seek_text(scpp_pkg::PREFIX_LEN, ",5");
      send_seek_text(scpp_pkg::PREFIX_LEN, "12,");
      send_seek_text(scpp_pkg::PREFIX_LEN, "12,a");
      send_seek_text(scpp_pkg::PREFIX_LEN - 1, ";1,2");
      packet_bytes.delete();
      add_text("x\n");
      add_tag(scpp_pkg::PREFIX_LEN);
      add_text("1,2");
      send_packet();
      drain();

      // overflow both the size and the newline index
      packet_bytes.delete();
      for (int i = 0; i < 65600; i++) begin
         b = 8'($urandom_range(255));
         if (b == scpp_pkg::CHAR_NEWLINE)
            b = 8'h0b;
         packet_bytes.push_back((i == 65550) ? scpp_pkg::CHAR_NEWLINE : b);
      end
      send_packet();
      drain();

      start      = words_sent;
      burst_done = 1'b0;
      paused     = 1'b0;
      while (words_sent - start < 1950) begin
         progress = words_sent - start;
         if (!burst_done && progress >= 500) begin
            hold_request = 1'b1;
            repeat (30) begin
               make_random_packet(1'b1);
               send_packet();
            end
            burst_done = 1'b1;
         end
         calm = (progress >= 900) && (progress < 1300);
         if (!paused && progress >= 1500) begin
            drain();
            paused = 1'b1;
         end
         make_random_packet(1'b0);
         send_packet();
      end
      calm = 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && results_due == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
design/scpp_pkg.sv
design/scpp_if.sv
design/seek_command_packet_parser.sv
verif/packet_verdict_monitor.sv
verif/tb.sv
